// ----- hdl/itbd_pkg.sv -----
// Shared constants, command/status structs and digit encoding for the radix converter.
package itbd_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int QUOT_W      = VALUE_WIDTH - 1;
	localparam int STACK_DEPTH = QUOT_W;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int STEP_W      = $clog2(QUOT_W);
	localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] MIN_RADIX   = 6'd2;
	localparam logic [RADIX_W-1:0] MAX_RADIX   = 6'd36;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;

	// controller -> datapath
	typedef struct packed {
		logic load;      // start a new conversion
		logic div_step;  // one restoring division bit
		logic rd;        // fetch the top of the digit stack
		logic out_load;  // move fetched digit into the output register
	} itbd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_ok;     // value positive and radix usable
		logic div_done;  // last bit of last division this cycle
		logic out_free;  // output register can take a word
		logic pop_last;  // stack holds only one digit
	} itbd_sts_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS)
			c = CHAR_ZERO + CHAR_W'(d);
		else
			c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
		return c;
	endfunction

endpackage

// ----- hdl/itbd_ctrl.sv -----
// Controller state machine: sequences division, digit stack readout and output.
module itbd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  itbd_pkg::itbd_sts_t  sts,
	output itbd_pkg::itbd_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_LD   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// words that give no digits are taken and dropped
				if (in_valid && sts.in_ok) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done)
					state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sts.pop_last ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- hdl/itbd_dpath.sv -----
// Datapath: radix register, bit-serial divider, digit stack and output register.
module itbd_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [itbd_pkg::RADIX_W-1:0]         cfg_wdata,
	input  logic [itbd_pkg::VALUE_WIDTH-1:0]     in_value,
	input  itbd_pkg::itbd_cmd_t                  cmd,
	output itbd_pkg::itbd_sts_t                  sts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [itbd_pkg::CHAR_W-1:0]          out_char,
	output logic                                 out_last
);

	logic [itbd_pkg::RADIX_W-1:0]  radix_q;
	logic [itbd_pkg::QUOT_W-1:0]   quot_q, quot_d;
	logic [itbd_pkg::DIGIT_W-1:0]  rem_q;
	logic [itbd_pkg::DIGIT_W:0]    trial, diff;
	logic                          qbit;
	logic [itbd_pkg::DIGIT_W-1:0]  rem_d;
	logic [itbd_pkg::STEP_W-1:0]   step_q;
	logic                          step_last;
	logic [itbd_pkg::CNT_W-1:0]    cnt_q;
	logic [itbd_pkg::DIGIT_W-1:0]  stack_mem [itbd_pkg::STACK_DEPTH];
	logic [itbd_pkg::DIGIT_W-1:0]  rd_q;
	logic [itbd_pkg::PTR_W-1:0]    wr_ptr, rd_ptr;
	logic                          out_valid_q;
	logic [itbd_pkg::CHAR_W-1:0]   out_char_q;
	logic                          out_last_q;

	// radix register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= itbd_pkg::RADIX_RESET;
		else if (cfg_we)
			radix_q <= cfg_wdata;
	end

	assign sts.in_ok = !in_value[itbd_pkg::VALUE_WIDTH-1]
		&& (in_value != '0)
		&& (radix_q >= itbd_pkg::MIN_RADIX)
		&& (radix_q <= itbd_pkg::MAX_RADIX);

	// restoring division, one quotient bit a cycle
	assign trial     = {rem_q, quot_q[itbd_pkg::QUOT_W-1]};
	assign diff      = trial - {1'b0, radix_q};
	assign qbit      = (trial >= {1'b0, radix_q});
	assign rem_d     = qbit ? diff[itbd_pkg::DIGIT_W-1:0] : trial[itbd_pkg::DIGIT_W-1:0];
	assign quot_d    = {quot_q[itbd_pkg::QUOT_W-2:0], qbit};
	assign step_last = (step_q == itbd_pkg::STEP_W'(itbd_pkg::QUOT_W - 1));

	assign sts.div_done = step_last && ((quot_d == '0)
		|| (cnt_q == itbd_pkg::CNT_W'(itbd_pkg::STACK_DEPTH - 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			if (step_last) begin
				step_q <= '0;
				cnt_q  <= cnt_q + 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else if (cmd.out_load) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q <= in_value[itbd_pkg::QUOT_W-1:0];
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quot_q <= quot_d;
			rem_q  <= step_last ? '0 : rem_d;
		end
	end

	// digit stack: pushed least significant first, popped from the top
	assign wr_ptr = cnt_q[itbd_pkg::PTR_W-1:0];
	assign rd_ptr = wr_ptr - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.div_step && step_last)
			stack_mem[wr_ptr] <= rem_d;
		if (cmd.rd)
			rd_q <= stack_mem[rd_ptr];
	end

	assign sts.pop_last = (cnt_q == itbd_pkg::CNT_W'(1));

	// output register
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char_q <= itbd_pkg::digit_to_ascii(rd_q);
			out_last_q <= sts.pop_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && step_last |-> cnt_q < itbd_pkg::CNT_W'(itbd_pkg::STACK_DEPTH))
		else $error("digit stack overflow");
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < radix_q)
		else $error("partial remainder not below radix");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> cnt_q != '0)
		else $error("read from empty digit stack");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("output word overwritten before it was taken");
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && sts.pop_last |=> cnt_q == '0)
		else $error("stack not empty after last digit");
`endif

endmodule

// ----- hdl/integer_to_base_digits_top.sv -----
// Signed integer to ASCII digit converter in a configurable radix, top level.
//
// Usage:
//   s_axis: one word per integer (two's complement in tdata). A word is taken at
//   tvalid & tready. Zero, negative values, or a radix outside 2..36 are taken
//   and give no output.
//   m_axis: one word per digit, most significant first, ASCII '0'-'9','A'-'Z' in
//   tdata[6:0]; tlast marks the least significant digit.
//   cfg_we/cfg_wdata write the radix (reset 10); write only while idle.
// Operation:
//   Each digit costs one pass of the bit-serial divider over all quotient bits.
//   All digits are divided out onto the stack first; each is then popped into
//   the output register through a read state and a load state. The next integer
//   is taken once the last digit has entered the output register.
// Reset clears the controller, the output register valid and sets the radix to 10.
// A stall on m_axis holds the output word and halts the readout; the
// divider finishes all digits before readout starts, so it never waits.
module integer_to_base_digits_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [itbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] value
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [itbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [6:0] digit_char
	output logic                                 m_axis_tlast,
	input  logic                                 cfg_we,
	input  logic [itbd_pkg::RADIX_W-1:0]         cfg_wdata
);

	itbd_pkg::itbd_cmd_t          cmd;
	itbd_pkg::itbd_sts_t          sts;
	logic [itbd_pkg::CHAR_W-1:0]  out_char;

	itbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itbd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_value  (s_axis_tdata[itbd_pkg::VALUE_WIDTH-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = itbd_pkg::OUT_TDATA_W'(out_char);

endmodule

// ----- sim/digit_stream_checker.sv -----
// Checker for the radix converter: predicts the digit stream and compares it word by word.
`timescale 1ns / 1ps

module digit_stream_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	input  logic [itbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] value
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [itbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [6:0] digit_char
	input  logic                                 m_axis_tlast,
	input  logic                                 cfg_we,
	input  logic [itbd_pkg::RADIX_W-1:0]         cfg_wdata,
	output int                                   digit_errors,
	output int                                   digits_due
);

	typedef struct packed {
		logic [itbd_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} digit_word_t;

	logic [itbd_pkg::RADIX_W-1:0] radix_q;
	digit_word_t                  expected_digits[$];

	// Repeated division, digits stacked least significant first, queued most significant first
	function automatic void predict_digits(input logic [itbd_pkg::VALUE_WIDTH-1:0] v);
		logic [itbd_pkg::DIGIT_W-1:0]     stack_img [itbd_pkg::STACK_DEPTH];
		logic [itbd_pkg::VALUE_WIDTH-1:0] quo;
		logic [itbd_pkg::DIGIT_W-1:0]     d;
		int                               n;
		digit_word_t                      w;
		n = 0;
		if (radix_q < itbd_pkg::MIN_RADIX || radix_q > itbd_pkg::MAX_RADIX)
			return;
		if (v[itbd_pkg::VALUE_WIDTH-1] || v == '0)
			return;
		quo = v;
		while (quo != '0 && n < itbd_pkg::STACK_DEPTH) begin
			stack_img[n] = itbd_pkg::DIGIT_W'(quo % radix_q);
			quo = quo / radix_q;
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			d = stack_img[k];
			if (d < itbd_pkg::DEC_DIGITS)
				w.ch = itbd_pkg::CHAR_ZERO + itbd_pkg::CHAR_W'(d);
			else
				w.ch = itbd_pkg::CHAR_A + itbd_pkg::CHAR_W'(d - itbd_pkg::DEC_DIGITS);
			w.last = (k == 0);
			expected_digits.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		digit_word_t exp_w;
		if (!arst_n) begin
			radix_q <= itbd_pkg::RADIX_RESET;
			digit_errors = 0;
			digits_due   = 0;
		end else begin
			// result side first so a word is never matched against the item taken this edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_digits.size() == 0) begin
					$error("digit_char: expected none, actual %0d (last %0d)",
						m_axis_tdata, m_axis_tlast);
					digit_errors++;
				end else begin
					exp_w = expected_digits.pop_front();
					if (m_axis_tdata !== itbd_pkg::OUT_TDATA_W'(exp_w.ch)) begin
						$error("digit_char: expected %0d, actual %0d", exp_w.ch, m_axis_tdata);
						digit_errors++;
					end
					if (m_axis_tlast !== exp_w.last) begin
						$error("last_digit: expected %0d, actual %0d", exp_w.last, m_axis_tlast);
						digit_errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_digits(s_axis_tdata[itbd_pkg::VALUE_WIDTH-1:0]);
			if (cfg_we)
				radix_q <= cfg_wdata;
			digits_due = expected_digits.size();
		end
	end

endmodule

// ----- sim/integer_to_base_digits_top_test.sv -----
// Testbench top for the radix converter: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module integer_to_base_digits_top_test;

	localparam int HOLD_CYCLES  = 1500;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 1100;   // settling wait once every digit is out
	localparam int STALL_LIMIT  = 20000;  // cycles with no word moved before giving up
	localparam int ITEMS_PER_PHASE = 36;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_axis_tvalid;
	logic                                 s_axis_tready;
	logic [itbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata;   // [31:0] value
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready;
	logic [itbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;   // [6:0] digit_char
	logic                                 m_axis_tlast;
	logic                                 cfg_we;
	logic [itbd_pkg::RADIX_W-1:0]         cfg_wdata;

	int digit_errors;
	int digits_due;
	int burst_left;
	int idle_cycles;
	bit quiet;
	bit hold_req;

	integer_to_base_digits_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	digit_stream_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.digit_errors  (digit_errors),
		.digits_due    (digits_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// offer one integer, returning at the edge where it is taken; valid stays high
	task automatic send_value(input logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
	endtask

	// radix change only once every digit is out and the block has settled
	task automatic set_radix(input logic [itbd_pkg::RADIX_W-1:0] r);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (digits_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly positive values of random magnitude, some zero or negative noise
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		int          len;
		if ($urandom_range(0, 9) == 0) begin
			v = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom() | 32'h8000_0000);
		end else begin
			len = $urandom_range(1, 31);
			v = $urandom() & ((32'd1 << len) - 32'd1);
			if (v == 32'd0)
				v = 32'd1;
		end
		return v;
	endfunction

	initial begin
		int          counted;
		logic [31:0] v;
		logic [5:0]  r;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		burst_left    = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// radix 10 out of reset: smallest, boundaries, largest, and the silent cases
		send_value(32'd1);
		send_value(32'd9);
		send_value(32'd10);
		send_value(32'h7FFF_FFFF);
		send_value(32'd1_000_000_000);
		send_value(32'd0);
		send_value(32'hFFFF_FFFF);
		send_value(32'h8000_0000);

		set_radix(6'd36);
		send_value(32'd35);
		send_value(32'd36);
		send_value(32'd1295);
		send_value(32'h7FFF_FFFF);

		// radix 2 gives the longest run, 31 digits
		set_radix(6'd2);
		send_value(32'd1);
		send_value(32'h7FFF_FFFF);
		send_value(32'h4000_0000);

		set_radix(6'd16);
		send_value(32'h7FED_CBA9);
		send_value(32'h0ABC_DEF0);

		// unusable radices: words are taken, nothing comes out
		set_radix(6'd0);
		send_value(32'd12345);
		set_radix(6'd1);
		send_value(32'd12345);
		set_radix(6'd37);
		send_value(32'd12345);
		set_radix(6'd63);
		send_value(32'd12345);

		set_radix(6'd3);
		send_value(32'h7FFF_FFFF);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: r = 6'd10;
				1: r = 6'd2;
				2: r = 6'd36;
				default: r = 6'($urandom_range(3, 35));
			endcase
			set_radix(r);
			quiet = (p == 1);
			if (p == 0)
				hold_req = 1'b1;
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				v = random_value();
				send_value(v);
				if (!v[31] && v != 32'd0)
					counted++;
			end
		end
		s_axis_tvalid <= 1'b0;
		quiet = 1'b0;

		@(posedge clk);
		while (digits_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (digit_errors == 0 && digits_due == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// receiver: random stall ratio, redrawn for each random-length pattern, plus one long hold-off
	initial begin
		int stall_pct;
		int pattern_left;
		bit hold_done;
		m_axis_tready = 1'b0;
		stall_pct     = 30;
		pattern_left  = 0;
		hold_done     = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				m_axis_tready <= 1'b1;
			end else if (quiet) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (pattern_left == 0) begin
					stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
					pattern_left = $urandom_range(8, 64);
				end
				pattern_left--;
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// watchdog on cycles in which no word moves on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
